// ===== rtl/core/str_pkg.sv =====
// Shared types and constants for the spiral trajectory rollout.
// Used by every module under rtl/core; depends on nothing else.
package str_pkg;

    localparam int CNT_W         = 6;
    localparam int CORDIC_STAGES = 14;
    localparam int CORDIC_XW     = 20;
    localparam int CORDIC_ZW     = 18;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_START = 20'sd39797;
    localparam int DIV_SHIFT     = 27;

    typedef enum logic [1:0] {
        REG_MAX_SPEED        = 2'd0,
        REG_STEP_TIME        = 2'd1,
        REG_TURN_RATE_LIMIT  = 2'd2,
        REG_TURN_ACCEL_LIMIT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        start_heading;
        logic [2:0]         speed_index;
        logic [2:0]         turn_rate_index;
        logic [2:0]         turn_accel_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [CNT_W-1:0]   point_number;
        logic               last_point;
    } point_t;

    // Per-trajectory constants handed from setup to the generator.
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        heading;
        logic [31:0]        sdt;
        logic signed [16:0] rate0;
        logic signed [17:0] drate;
    } setup_t;

    // One point in flight through the CORDIC and accumulator.
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        heading;
        logic [31:0]        sdt;
        logic [CNT_W-1:0]   cnt;
        logic               first;
        logic               last;
    } tok_t;

    typedef struct packed {
        logic             busy;
        logic             load;
        logic [CNT_W-1:0] cnt;
    } gen_stat_t;

    function automatic logic signed [CORDIC_ZW-1:0] cordic_angle(input int unsigned i);
        case (i)
            0:       return 18'sd8192;
            1:       return 18'sd4836;
            2:       return 18'sd2555;
            3:       return 18'sd1297;
            4:       return 18'sd651;
            5:       return 18'sd326;
            6:       return 18'sd163;
            7:       return 18'sd81;
            8:       return 18'sd41;
            9:       return 18'sd20;
            10:      return 18'sd10;
            11:      return 18'sd5;
            12:      return 18'sd3;
            13:      return 18'sd1;
            default: return 18'sd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/str_setup.sv =====
// Three-stage setup pipeline: sample indices to speed, start turn rate and
// turn acceleration step. Depends on str_pkg.
module str_setup
    import str_pkg::*;
#(
    parameter int SPEED_SAMPLES = 8,
    parameter int RATE_SAMPLES  = 6,
    parameter int ACCEL_SAMPLES = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic        in_valid,
    input  req_t        req,
    input  logic [15:0] max_speed,
    input  logic [15:0] step_time,
    input  logic [14:0] turn_rate_limit,
    input  logic [14:0] turn_accel_limit,
    output logic        out_valid,
    output setup_t      out_data
);

    localparam int DS    = SPEED_SAMPLES - 1;
    localparam int DR    = RATE_SAMPLES - 1;
    localparam int DA    = ACCEL_SAMPLES - 1;
    localparam int DIV_S = 2 * DS;
    localparam int DIV_R = 2 * DR;
    localparam int DIV_A = 2 * DA;
    localparam logic [27:0] M_S = 28'(((1 << DIV_SHIFT) + DIV_S - 1) / DIV_S);
    localparam logic [27:0] M_R = 28'(((1 << DIV_SHIFT) + DIV_R - 1) / DIV_R);
    localparam logic [27:0] M_A = 28'(((1 << DIV_SHIFT) + DIV_A - 1) / DIV_A);

    logic        v1_reg, v2_reg, v3_reg;
    logic [3:0]  si, ri, ai;
    logic [20:0] vs_next, vr_next, va_next;
    logic [20:0] vs_reg, vr_reg, va_reg;
    logic [47:0] ps, pr, pa;
    logic signed [31:0] sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic [15:0] h1_reg, h2_reg;
    logic [15:0] speed_reg;
    logic signed [16:0] rate0_reg, accel_reg;
    logic signed [33:0] ap, ar;
    setup_t      s3_reg;

    always_comb
    begin
        si = ({1'b0, req.speed_index} > 4'(DS)) ? 4'(DS) : {1'b0, req.speed_index};
        ri = ({1'b0, req.turn_rate_index} > 4'(DR)) ? 4'(DR) : {1'b0, req.turn_rate_index};
        ai = ({1'b0, req.turn_accel_index} > 4'(DA)) ? 4'(DA) : {1'b0, req.turn_accel_index};
        vs_next = 21'(max_speed) * 21'(si) * 21'd2 + 21'(DS);
        vr_next = 21'(turn_rate_limit) * 21'(ri) * 21'd4 + 21'(DR);
        va_next = 21'(turn_accel_limit) * 21'(ai) * 21'd4 + 21'(DA);
    end

    // Division by the sample spacing is a multiply by its rounded-up reciprocal.
    assign ps = 48'(vs_reg) * 48'(M_S);
    assign pr = 48'(vr_reg) * 48'(M_R);
    assign pa = 48'(va_reg) * 48'(M_A);

    assign ap = 34'(accel_reg) * 34'($signed({1'b0, step_time}));
    assign ar = ap + 34'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (go)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            vs_reg    <= vs_next;
            vr_reg    <= vr_next;
            va_reg    <= va_next;
            sx1_reg   <= req.start_x;
            sy1_reg   <= req.start_y;
            h1_reg    <= req.start_heading;
            speed_reg <= ps[DIV_SHIFT+15:DIV_SHIFT];
            rate0_reg <= $signed({1'b0, pr[DIV_SHIFT+15:DIV_SHIFT]})
                         - $signed({2'b00, turn_rate_limit});
            accel_reg <= $signed({1'b0, pa[DIV_SHIFT+15:DIV_SHIFT]})
                         - $signed({2'b00, turn_accel_limit});
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            h2_reg    <= h1_reg;
            s3_reg.start_x <= sx2_reg;
            s3_reg.start_y <= sy2_reg;
            s3_reg.heading <= h2_reg;
            s3_reg.sdt     <= 32'(speed_reg) * 32'(step_time);
            s3_reg.rate0   <= rate0_reg;
            s3_reg.drate   <= ar[33:16];
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule

// ===== rtl/core/str_gen.sv =====
// Step generator: while busy and not stalled, walks heading and turn rate one step
// per cycle and emits one point request per cycle. Depends on str_pkg.
module str_gen
    import str_pkg::*;
#(
    parameter int STEPS = 40
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        setup_valid,
    input  setup_t      setup,
    input  logic [15:0] step_time,
    output logic        tok_valid,
    output tok_t        tok,
    output gen_stat_t   stat
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS);

    logic               busy_reg, tok_valid_reg, load;
    logic [CNT_W-1:0]   cnt_reg;
    logic [15:0]        heading_reg, heading_next;
    logic signed [23:0] rate_reg, rate_next;
    logic signed [17:0] drate_reg;
    logic [31:0]        sdt_reg;
    logic signed [31:0] sx_reg, sy_reg;
    logic signed [40:0] yp, yr;
    logic signed [24:0] rsum;
    tok_t               tok_reg;

    assign load = en && setup_valid && (!busy_reg || cnt_reg == LAST_CNT);

    always_comb
    begin
        yp = 41'(rate_reg) * 41'($signed({1'b0, step_time}));
        yr = yp + 41'sd32768;
        heading_next = heading_reg + yr[31:16];
        rsum = 25'(rate_reg) + 25'(drate_reg);
        if (rsum > 25'sd8388607)
            rate_next = 24'sh7FFFFF;
        else if (rsum < -25'sd8388608)
            rate_next = 24'sh800000;
        else
            rate_next = rsum[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            tok_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tok_valid_reg <= busy_reg;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_CNT)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg.start_x <= sx_reg;
            tok_reg.start_y <= sy_reg;
            tok_reg.heading <= heading_reg;
            tok_reg.sdt     <= sdt_reg;
            tok_reg.cnt     <= cnt_reg;
            tok_reg.first   <= (cnt_reg == '0);
            tok_reg.last    <= (cnt_reg == LAST_CNT);
            if (load)
            begin
                heading_reg <= setup.heading;
                rate_reg    <= 24'(setup.rate0);
                drate_reg   <= setup.drate;
                sdt_reg     <= setup.sdt;
                sx_reg      <= setup.start_x;
                sy_reg      <= setup.start_y;
            end
            else if (busy_reg)
            begin
                heading_reg <= heading_next;
                rate_reg    <= rate_next;
            end
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;
    assign stat      = '{busy: busy_reg, load: load, cnt: cnt_reg};

endmodule

// ===== rtl/core/str_cordic.sv =====
// Pipelined CORDIC, one rotation per stage, giving cos and sin of the heading
// with a quadrant flip flag. Depends on str_pkg.
module str_cordic
    import str_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  tok_t                        in_tok,
    output logic                        out_valid,
    output tok_t                        out_tok,
    output logic signed [CORDIC_XW-1:0] cos_val,
    output logic signed [CORDIC_XW-1:0] sin_val,
    output logic                        flip
);

    logic signed [CORDIC_XW-1:0] x_in [CORDIC_STAGES];
    logic signed [CORDIC_XW-1:0] y_in [CORDIC_STAGES];
    logic signed [CORDIC_ZW-1:0] z_in [CORDIC_STAGES];
    logic                        f_in [CORDIC_STAGES];
    logic                        v_in [CORDIC_STAGES];
    tok_t                        t_in [CORDIC_STAGES];
    logic signed [CORDIC_XW-1:0] x_reg [CORDIC_STAGES];
    logic signed [CORDIC_XW-1:0] y_reg [CORDIC_STAGES];
    logic signed [CORDIC_ZW-1:0] z_reg [CORDIC_STAGES];
    logic                        f_reg [CORDIC_STAGES];
    logic                        v_reg [CORDIC_STAGES];
    tok_t                        t_reg [CORDIC_STAGES];
    logic signed [CORDIC_ZW-1:0] z_fold;
    logic                        f_fold;

    // Fold the heading into the right half-plane; the result is negated later.
    always_comb
    begin
        z_fold = CORDIC_ZW'($signed(in_tok.heading));
        f_fold = 1'b0;
        if (z_fold > 18'sd16384)
        begin
            z_fold = z_fold - 18'sd32768;
            f_fold = 1'b1;
        end
        else if (z_fold < -18'sd16384)
        begin
            z_fold = z_fold + 18'sd32768;
            f_fold = 1'b1;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            if (i == 0)
            begin : g_first
                assign x_in[i] = CORDIC_START;
                assign y_in[i] = '0;
                assign z_in[i] = z_fold;
                assign f_in[i] = f_fold;
                assign v_in[i] = in_valid;
                assign t_in[i] = in_tok;
            end
            else
            begin : g_next
                assign x_in[i] = x_reg[i-1];
                assign y_in[i] = y_reg[i-1];
                assign z_in[i] = z_reg[i-1];
                assign f_in[i] = f_reg[i-1];
                assign v_in[i] = v_reg[i-1];
                assign t_in[i] = t_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_in[i];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_in[i][CORDIC_ZW-1])
                    begin
                        x_reg[i] <= x_in[i] - (y_in[i] >>> i);
                        y_reg[i] <= y_in[i] + (x_in[i] >>> i);
                        z_reg[i] <= z_in[i] - cordic_angle(i);
                    end
                    else
                    begin
                        x_reg[i] <= x_in[i] + (y_in[i] >>> i);
                        y_reg[i] <= y_in[i] - (x_in[i] >>> i);
                        z_reg[i] <= z_in[i] + cordic_angle(i);
                    end
                    f_reg[i] <= f_in[i];
                    t_reg[i] <= t_in[i];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[CORDIC_STAGES-1];
    assign out_tok   = t_reg[CORDIC_STAGES-1];
    assign cos_val   = x_reg[CORDIC_STAGES-1];
    assign sin_val   = y_reg[CORDIC_STAGES-1];
    assign flip      = f_reg[CORDIC_STAGES-1];

endmodule

// ===== rtl/core/str_accum.sv =====
// Position path: scales cos and sin by speed times step, rounds, and runs the
// saturating x and y accumulators that drive the point register. Depends on str_pkg.
module str_accum
    import str_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  tok_t                        in_tok,
    input  logic signed [CORDIC_XW-1:0] cos_val,
    input  logic signed [CORDIC_XW-1:0] sin_val,
    input  logic                        flip,
    output logic                        out_valid,
    output point_t                      out_point
);

    logic signed [CORDIC_XW:0] c_s, s_s;
    logic signed [53:0]        px_next, py_next, px_reg, py_reg, rx, ry;
    logic signed [25:0]        dx_reg, dy_reg;
    logic                      vm_reg, vr_reg, vo_reg;
    tok_t                      tm_reg, tr_reg;
    logic signed [31:0]        base_x, base_y, acc_x_reg, acc_y_reg;
    logic signed [32:0]        sum_x, sum_y;
    point_t                    pt_reg;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -33'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    always_comb
    begin
        c_s = flip ? -(CORDIC_XW+1)'(cos_val) : (CORDIC_XW+1)'(cos_val);
        s_s = flip ? -(CORDIC_XW+1)'(sin_val) : (CORDIC_XW+1)'(sin_val);
        px_next = 54'($signed({1'b0, in_tok.sdt})) * 54'(c_s);
        py_next = 54'($signed({1'b0, in_tok.sdt})) * 54'(s_s);
        rx = px_reg + 54'sd134217728;
        ry = py_reg + 54'sd134217728;
        base_x = tr_reg.first ? tr_reg.start_x : acc_x_reg;
        base_y = tr_reg.first ? tr_reg.start_y : acc_y_reg;
        sum_x = 33'(base_x) + 33'(dx_reg);
        sum_y = 33'(base_y) + 33'(dy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= in_valid;
            vr_reg <= vm_reg;
            vo_reg <= vr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            tm_reg <= in_tok;
            dx_reg <= rx[53:28];
            dy_reg <= ry[53:28];
            tr_reg <= tm_reg;
            if (vr_reg)
            begin
                acc_x_reg <= sat32(sum_x);
                acc_y_reg <= sat32(sum_y);
            end
            pt_reg.point_x      <= base_x;
            pt_reg.point_y      <= base_y;
            pt_reg.point_number <= tr_reg.cnt;
            pt_reg.last_point   <= tr_reg.last;
        end
    end

    assign out_valid = vo_reg;
    assign out_point = pt_reg;

endmodule

// ===== rtl/core/spiral_trajectory_rollout.sv =====
// Top level of the spiral trajectory rollout: configuration registers, setup,
// step generator, CORDIC and position accumulator. Depends on str_pkg.
//
// Each request gives a start pose and three sample indices and yields STEPS+1
// points, the last one marked, one per cycle while the point port does not stall;
// a request already waiting in setup is taken so that its first point follows the
// previous trajectory's last point with no gap. The step generator sets that pace,
// its heading and turn-rate update running once per point. The first point of a
// request passes 3 setup stages, 2 generator stages, 14 CORDIC stages and 3
// position stages, the last of which is the point register. A stall on the point
// port holds the whole pipeline; nothing is dropped or repeated.
module spiral_trajectory_rollout
    import str_pkg::*;
#(
    parameter int STEPS         = 40,
    parameter int SPEED_SAMPLES = 8,
    parameter int RATE_SAMPLES  = 6,
    parameter int ACCEL_SAMPLES = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        point_valid,
    input  logic        point_ready,
    output point_t      point,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] max_speed_reg, step_time_reg;
    logic [14:0] rate_lim_reg, accel_lim_reg;
    logic        en, setup_valid, tok_valid, cv, go;
    setup_t      setup;
    tok_t        tok, ctok;
    gen_stat_t   gstat;
    logic signed [CORDIC_XW-1:0] cval, sval;
    logic        cflip;

    assign en        = !point_valid || point_ready;
    assign go        = en && (!setup_valid || gstat.load);
    assign req_ready = go;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= 16'd12288;
            step_time_reg <= 16'd6554;
            rate_lim_reg  <= 15'd5461;
            accel_lim_reg <= 15'd5215;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MAX_SPEED:        max_speed_reg <= cfg_data;
                REG_STEP_TIME:        step_time_reg <= cfg_data;
                REG_TURN_RATE_LIMIT:  rate_lim_reg  <= cfg_data[14:0];
                REG_TURN_ACCEL_LIMIT: accel_lim_reg <= cfg_data[14:0];
                default:              ;
            endcase
        end
    end

    str_setup #(
        .SPEED_SAMPLES (SPEED_SAMPLES),
        .RATE_SAMPLES  (RATE_SAMPLES),
        .ACCEL_SAMPLES (ACCEL_SAMPLES)
    ) u_setup (
        .clk              (clk),
        .rst_n            (rst_n),
        .go               (go),
        .in_valid         (req_valid),
        .req              (req),
        .max_speed        (max_speed_reg),
        .step_time        (step_time_reg),
        .turn_rate_limit  (rate_lim_reg),
        .turn_accel_limit (accel_lim_reg),
        .out_valid        (setup_valid),
        .out_data         (setup)
    );

    str_gen #(
        .STEPS (STEPS)
    ) u_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .setup_valid (setup_valid),
        .setup       (setup),
        .step_time   (step_time_reg),
        .tok_valid   (tok_valid),
        .tok         (tok),
        .stat        (gstat)
    );

    str_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tok_valid),
        .in_tok    (tok),
        .out_valid (cv),
        .out_tok   (ctok),
        .cos_val   (cval),
        .sin_val   (sval),
        .flip      (cflip)
    );

    str_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cv),
        .in_tok    (ctok),
        .cos_val   (cval),
        .sin_val   (sval),
        .flip      (cflip),
        .out_valid (point_valid),
        .out_point (point)
    );

    a_last_number: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point.last_point |-> point.point_number == CNT_W'(STEPS))
        else $error("last point carries the wrong step number");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        gstat.load |-> (!gstat.busy || gstat.cnt == CNT_W'(STEPS)))
        else $error("generator reloaded in the middle of a trajectory");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        gstat.busy |-> gstat.cnt <= CNT_W'(STEPS))
        else $error("step counter ran past the last step");

    a_req_load: assert property (@(posedge clk) disable iff (!rst_n)
        gstat.load |=> gstat.busy && gstat.cnt == '0)
        else $error("generator did not start at step zero");

endmodule

// ===== tb/spiral_trajectory_rollout_test.sv =====
// Self-checking testbench for spiral_trajectory_rollout: drives trajectory requests
// and register writes, predicts every point and compares it. Depends on str_pkg.
`timescale 1ns / 100ps

module spiral_trajectory_rollout_test;
    import str_pkg::*;

    localparam int STEPS = 40;
    localparam int SPEED_SAMPLES = 8;
    localparam int RATE_SAMPLES = 6;
    localparam int ACCEL_SAMPLES = 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        point_valid;
    logic        point_ready;
    point_t      point;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    spiral_trajectory_rollout dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of the registers.
    logic [15:0] mdl_max_speed;
    logic [15:0] mdl_step_time;
    logic [14:0] mdl_rate_limit;
    logic [14:0] mdl_accel_limit;

    req_t   pending_reqs[$];
    point_t expected_points[$];
    int     error_count;
    int     idle_cycles;
    bit     sender_hold;
    bit     req_accepted;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint floor_div_pow2(longint v, int k);
        return v >>> k;
    endfunction

    function automatic void heading_cos_sin(input logic [15:0] h,
                                            output longint c, output longint s);
        int     z;
        bit     flip;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        int     angles[CORDIC_STAGES];
        angles = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        z = (h < 16'd32768) ? int'(h) : int'(h) - 65536;
        flip = 1'b0;
        cx = 39797;
        cy = 0;
        if (z > 16384) begin
            z -= 32768;
            flip = 1'b1;
        end else if (z < -16384) begin
            z += 32768;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = floor_div_pow2(cy, i);
            dy = floor_div_pow2(cx, i);
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z -= angles[i];
            end else begin
                cx += dx;
                cy -= dy;
                z += angles[i];
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endfunction

    function automatic longint signed_sample(longint lim, int idx, int d);
        longint i;
        i = (idx > d) ? d : idx;
        return (2 * lim * i * 2 + d) / (2 * d) - lim;
    endfunction

    function automatic longint sat_pos(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic queue_request(input req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic predict_trajectory(input req_t r);
        longint speed;
        longint rate;
        longint accel;
        longint sdt;
        longint x;
        longint y;
        longint c;
        longint s;
        longint dyaw;
        longint drate;
        logic [15:0] heading;
        int si;
        point_t p;
        si = (r.speed_index > SPEED_SAMPLES - 1) ? SPEED_SAMPLES - 1 : r.speed_index;
        speed = (longint'(mdl_max_speed) * si * 2 + (SPEED_SAMPLES - 1))
                / (2 * (SPEED_SAMPLES - 1));
        rate = signed_sample(mdl_rate_limit, r.turn_rate_index, RATE_SAMPLES - 1);
        accel = signed_sample(mdl_accel_limit, r.turn_accel_index, ACCEL_SAMPLES - 1);
        sdt = speed * longint'(mdl_step_time);
        x = r.start_x;
        y = r.start_y;
        heading = r.start_heading;
        for (int n = 0; n <= STEPS; n++) begin
            p.point_x = x[31:0];
            p.point_y = y[31:0];
            p.point_number = n[CNT_W-1:0];
            p.last_point = (n == STEPS);
            expected_points.insert(expected_points.size(), p);
            if (n == STEPS) break;
            heading_cos_sin(heading, c, s);
            x = sat_pos(x + floor_div_pow2(sdt * c + (64'sd1 << 27), 28));
            y = sat_pos(y + floor_div_pow2(sdt * s + (64'sd1 << 27), 28));
            dyaw = floor_div_pow2(rate * longint'(mdl_step_time) + 32768, 16);
            heading = heading + dyaw[15:0];
            drate = floor_div_pow2(accel * longint'(mdl_step_time) + 32768, 16);
            rate = rate + drate;
            if (rate > 8388607) rate = 8388607;
            if (rate < -8388608) rate = -8388608;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Request driver.
    int send_gap;
    always @(negedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_valid && req_accepted) begin
                send_gap = gap_length();
            end
            if (req_valid && !req_accepted) begin
                // Holding the current request until it is taken.
            end else if (send_gap > 0) begin
                send_gap--;
                req_valid <= 1'b0;
            end else if (!sender_hold && pending_reqs.size() > 0) begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Output stall generator.
    int stall_len;
    always @(negedge clk) begin
        if (!rst_n) begin
            point_ready <= 1'b0;
            stall_len = 0;
        end else if (stall_len > 0) begin
            stall_len--;
            point_ready <= 1'b0;
        end else begin
            point_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_len = gap_length();
        end
    end

    // Monitor: predicts on accepted requests and checks accepted points.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_accepted <= 1'b0;
        end else begin
            req_accepted <= req_valid && req_ready;
            if ((req_valid && req_ready) || (point_valid && point_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (req_valid && req_ready) begin
                predict_trajectory(req);
            end
            if (point_valid && point_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("point with no expectation");
                end else begin
                    point_t e;
                    e = expected_points.pop_front();
                    if (point.point_x !== e.point_x)
                        report_mismatch($sformatf("point_x %0d exp %0d",
                                        point.point_x, e.point_x));
                    if (point.point_y !== e.point_y)
                        report_mismatch($sformatf("point_y %0d exp %0d",
                                        point.point_y, e.point_y));
                    if (point.point_number !== e.point_number)
                        report_mismatch($sformatf("point_number %0d exp %0d",
                                        point.point_number, e.point_number));
                    if (point.last_point !== e.last_point)
                        report_mismatch($sformatf("last_point %0b exp %0b",
                                        point.last_point, e.last_point));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("spiral_trajectory_rollout_test: FAIL");
                $finish;
            end
        end
    end

    function automatic req_t random_request();
        req_t r;
        int mode;
        mode = $urandom_range(0, 9);
        r.start_x = $urandom();
        r.start_y = $urandom();
        if (mode < 6) begin
            r.start_x = $signed($urandom_range(0, 400000)) - 200000;
            r.start_y = $signed($urandom_range(0, 400000)) - 200000;
        end else if (mode == 6) begin
            r.start_x = $urandom_range(0, 1) ? 32'sh7FFF_F000 : 32'sh8000_1000;
            r.start_y = $urandom_range(0, 1) ? 32'sh7FFF_F000 : 32'sh8000_1000;
        end
        r.start_heading = 16'($urandom());
        r.speed_index = 3'($urandom());
        r.turn_rate_index = 3'($urandom());
        r.turn_accel_index = 3'($urandom());
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_MAX_SPEED:        mdl_max_speed = value;
            REG_STEP_TIME:        mdl_step_time = value;
            REG_TURN_RATE_LIMIT:  mdl_rate_limit = value[14:0];
            REG_TURN_ACCEL_LIMIT: mdl_accel_limit = value[14:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] spd, input logic [15:0] dt,
                             input logic [15:0] rl, input logic [15:0] al);
        write_register(REG_MAX_SPEED, spd);
        write_register(REG_STEP_TIME, dt);
        write_register(REG_TURN_RATE_LIMIT, rl);
        write_register(REG_TURN_ACCEL_LIMIT, al);
    endtask

    initial begin
        req_t r;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        point_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_SPEED;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        sender_hold = 1'b0;
        req_accepted = 1'b0;
        mdl_max_speed = 16'd12288;
        mdl_step_time = 16'd6554;
        mdl_rate_limit = 15'd5461;
        mdl_accel_limit = 15'd5215;
        repeat (11) @(posedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every index including the clamped ones,
        // saturation at both position limits, heading wrap.
        for (int i = 0; i < 8; i++) begin
            r.start_x = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            r.start_y = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            r.start_heading = (i % 2) ? 16'hFFFF : 16'h0000;
            r.speed_index = 3'(i);
            r.turn_rate_index = 3'(7 - i);
            r.turn_accel_index = 3'(i);
            queue_request(r);
        end
        for (int i = 0; i < 6; i++) begin
            r.start_x = 0;
            r.start_y = 0;
            r.start_heading = 16'(16'h4000 * i + 16'h3FFF);
            r.speed_index = 3'd7;
            r.turn_rate_index = 3'(i);
            r.turn_accel_index = 3'(5 - i);
            queue_request(r);
        end
        wait_drained();

        // The sender waits for the pipeline to empty before each phase.
        configure(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        for (int i = 0; i < 4; i++) queue_request(random_request());
        r = random_request();
        r.speed_index = 3'd7;
        r.turn_rate_index = 3'd5;
        r.turn_accel_index = 3'd5;
        queue_request(r);
        wait_drained();

        // Zero step time keeps every point at the start pose.
        configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < 4; i++) queue_request(random_request());
        wait_drained();

        configure(16'd12288, 16'd1, 16'd100, 16'd7);
        for (int i = 0; i < 4; i++) queue_request(random_request());
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            configure(16'($urandom()), 16'($urandom_range(1, 65535)),
                      16'($urandom()), 16'($urandom()));
            for (int i = 0; i < 30; i++) queue_request(random_request());
            if (phase == 1) begin
                // Let a few go, then stop sending until every point is back.
                while (pending_reqs.size() > 25) @(posedge clk);
                sender_hold = 1'b1;
                while (req_valid || expected_points.size() > 0) @(posedge clk);
                sender_hold = 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("spiral_trajectory_rollout_test: PASS");
        end else begin
            $display("spiral_trajectory_rollout_test: FAIL");
        end
        $finish;
    end

endmodule
